// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the training unit checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while reset is released.
`define ASSERT_ON(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Checked on every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("assertion failed");

`endif

// ===== design/q88_pkg.sv =====
// ----------------------------------------------------------------------------
// q88_pkg
// Types, constants and arithmetic helpers of the Q8.8 SGD training unit.
// ----------------------------------------------------------------------------
package q88_pkg;

  localparam int FRAC_BITS  = 8;
  localparam int NUM_OUT    = 2;
  localparam int NUM_HIDDEN = 4;
  localparam int NUM_IN     = 4;

  localparam int LOSS_N = (NUM_OUT < 2) ? NUM_OUT : 2;
  localparam int HID_N  = (NUM_HIDDEN < 4) ? NUM_HIDDEN : 4;
  localparam int UPD2_N = (NUM_OUT * NUM_HIDDEN < 8) ? NUM_OUT * NUM_HIDDEN : 8;
  localparam int UPD1_N = (NUM_HIDDEN * NUM_IN < 16) ? NUM_HIDDEN * NUM_IN : 16;

  localparam int SLOPE_W = FRAC_BITS + 1;
  localparam logic [SLOPE_W-1:0] ONE_Q = SLOPE_W'(1) << FRAC_BITS;
  localparam logic signed [63:0] HALF_Q = 64'sd1 <<< (FRAC_BITS - 1);

  localparam logic [6:0] ADDR_ACT  = 7'd0;
  localparam logic [6:0] ADDR_PRE  = 7'd4;
  localparam logic [6:0] ADDR_TGT  = 7'd8;
  localparam logic [6:0] ADDR_GRAD = 7'd12;
  localparam logic [6:0] ADDR_CMD  = 7'd28;
  localparam logic [6:0] ADDR_W1   = 7'd32;
  localparam logic [6:0] ADDR_W2   = 7'd48;
  localparam logic [6:0] ADDR_DOUT = 7'd64;
  localparam logic [6:0] ADDR_DHID = 7'd68;
  localparam logic [6:0] ADDR_LOSS = 7'd76;

  localparam int CMD_LOSS = 0;
  localparam int CMD_D1   = 1;
  localparam int CMD_UPD2 = 2;
  localparam int CMD_UPD1 = 3;
  localparam int CMD_CLR  = 4;

  localparam logic [1:0] CFG_LR    = 2'd0;
  localparam logic [1:0] CFG_LEAK  = 2'd1;
  localparam logic [1:0] CFG_ERR   = 2'd2;
  localparam logic [1:0] CFG_DELTA = 2'd3;

  typedef enum logic [1:0] {OP_READ, OP_WRITE, OP_CMD} op_kind_e;

  typedef struct packed {
    op_kind_e    kind;
    logic [6:0]  addr;
    logic [31:0] data;
  } op_t;

  typedef struct packed {
    logic push;
    logic full;
  } q_ctrl_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_ERR, ST_LMUL, ST_LACC, ST_HMUL, ST_HWR, ST_UPD2, ST_UPD1, ST_CLR
  } state_e;

  function automatic state_e first_phase(input logic [4:0] c);
    if (c[CMD_LOSS]) return ST_ERR;
    if (c[CMD_D1]) return ST_HMUL;
    if (c[CMD_UPD2]) return ST_UPD2;
    if (c[CMD_UPD1]) return ST_UPD1;
    if (c[CMD_CLR]) return ST_CLR;
    return ST_IDLE;
  endfunction

  function automatic logic signed [63:0] round_q(input logic signed [63:0] p);
    logic signed [63:0] s;
    s = p + HALF_Q;
    return s >>> FRAC_BITS;
  endfunction

  function automatic logic [31:0] clamp_lim(input logic signed [63:0] v,
                                            input logic [30:0] lim);
    logic signed [63:0] l;
    logic signed [63:0] r;
    l = (lim == 31'd0) ? 64'sd1 : signed'({33'd0, lim});
    if (v < -l) r = -l;
    else if (v > l - 64'sd1) r = l - 64'sd1;
    else r = v;
    return r[31:0];
  endfunction

  function automatic logic [31:0] sgd(input logic [31:0] w, input logic [31:0] g,
                                      input logic [3:0] sh);
    logic signed [32:0] d;
    logic signed [31:0] gs;
    gs = signed'(g) >>> sh;
    d = signed'({w[31], w}) - signed'({gs[31], gs});
    if (d > 33'sd32767) return 32'd32767;
    if (d < -33'sd32768) return 32'hFFFF_8000;
    return d[31:0];
  endfunction

endpackage

// ===== design/q88_front.sv =====
// ----------------------------------------------------------------------------
// q88_front
// Accepts bus beats and classifies each as read, plain write or command.
// ----------------------------------------------------------------------------
module q88_front import q88_pkg::*; (
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,
  input  logic        q_full_i,
  output q_ctrl_t     q_ctrl_o,
  output op_t         op_o
);

  logic [6:0] addr;

  assign addr          = s_axis_tdata[7:1];
  assign s_axis_tready = !q_full_i;
  assign q_ctrl_o.push = s_axis_tvalid && !q_full_i;
  assign q_ctrl_o.full = q_full_i;

  always_comb begin
    op_o.addr = addr;
    op_o.data = s_axis_tdata[39:8];
    if (!s_axis_tdata[0]) op_o.kind = OP_READ;
    else if (addr == ADDR_CMD) op_o.kind = OP_CMD;
    else op_o.kind = OP_WRITE;
  end

endmodule

// ===== design/q88_queue.sv =====
// ----------------------------------------------------------------------------
// q88_queue
// Two-entry queue of classified operations between front and back.
// ----------------------------------------------------------------------------
module q88_queue import q88_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  q_ctrl_t ctrl_i,
  input  op_t     op_i,
  output logic    full_o,
  output logic    valid_o,
  output op_t     op_o,
  input  logic    pop_i
);

  op_t        mem_q [2];
  logic       wr_q, wr_d, rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;

  assign full_o  = cnt_q == 2'd2;
  assign valid_o = cnt_q != 2'd0;
  assign op_o    = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q ^ ctrl_i.push;
    rd_d  = rd_q ^ pop_i;
    cnt_d = cnt_q + {1'b0, ctrl_i.push} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) mem_q[wr_q] <= op_i;
  end

endmodule

// ===== design/q88_back.sv =====
// ----------------------------------------------------------------------------
// q88_back
// Register banks, command sequencer, datapath and output register.
// ----------------------------------------------------------------------------
module q88_back import q88_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [30:0] cfg_data_i,
  input  logic        q_valid_i,
  input  op_t         q_op_i,
  output logic        q_pop_o,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata
);

  logic [31:0] act_q [4];
  logic [31:0] pre_q [4];
  logic [31:0] tgt_q [4];
  logic [31:0] grad_q [16];
  logic [31:0] w1_q [16];
  logic [31:0] w2_q [8];
  logic [31:0] dout_q [2];
  logic [31:0] dhid_q [4];
  logic [31:0] loss_q;

  logic [3:0]  lr_q;
  logic [2:0]  leak_q;
  logic [30:0] errc_q, dltc_q;

  state_e      state_q, state_d;
  logic [4:0]  cmd_q, cmd_d;
  logic [3:0]  idx_q, idx_d;
  logic        out_v_q, out_v_d;
  logic [31:0] out_q, rdata;

  logic signed [31:0] e_q;
  logic signed [63:0] sq_q, lk_q;
  logic signed [63:0] sq_rnd;
  logic [SLOPE_W-1:0] slope;
  logic signed [32:0] diff;
  logic        last;
  logic [4:0]  cmd_left;
  logic [6:0]  a, off;

  function automatic logic [3:0] off_grad(input logic [6:0] x);
    logic [6:0] d;
    d = x - ADDR_GRAD;
    return d[3:0];
  endfunction

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_q;
  assign a             = q_op_i.addr;
  assign sq_rnd        = round_q(sq_q);

  assign slope = pre_q[idx_q[1:0]][31] ? (ONE_Q >> leak_q) : ONE_Q;
  assign diff  = signed'({act_q[idx_q[1:0]][31], act_q[idx_q[1:0]]})
               - signed'({tgt_q[idx_q[1:0]][31], tgt_q[idx_q[1:0]]});

  always_comb begin
    rdata = 32'd0;
    off   = 7'd0;
    if (a >= ADDR_W1 && a < ADDR_W2) begin
      off = a - ADDR_W1;
      rdata = w1_q[off[3:0]];
    end else if (a >= ADDR_W2 && a < ADDR_W2 + 7'd8) begin
      off = a - ADDR_W2;
      rdata = w2_q[off[2:0]];
    end else if (a >= ADDR_DOUT && a < ADDR_DOUT + 7'd2) begin
      off = a - ADDR_DOUT;
      rdata = dout_q[off[0]];
    end else if (a >= ADDR_DHID && a < ADDR_DHID + 7'd4) begin
      off = a - ADDR_DHID;
      rdata = dhid_q[off[1:0]];
    end else if (a == ADDR_LOSS) begin
      rdata = loss_q;
    end
  end

  always_comb begin
    state_d  = state_q;
    cmd_d    = cmd_q;
    idx_d    = idx_q;
    q_pop_o  = 1'b0;
    out_v_d  = out_v_q && !m_axis_tready;
    last     = 1'b0;
    cmd_left = cmd_q;
    case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          case (q_op_i.kind)
            OP_READ: begin
              if (!out_v_q || m_axis_tready) begin
                q_pop_o = 1'b1;
                out_v_d = 1'b1;
              end
            end
            OP_CMD: begin
              q_pop_o = 1'b1;
              cmd_d   = q_op_i.data[4:0];
              idx_d   = 4'd0;
              state_d = first_phase(q_op_i.data[4:0]);
            end
            default: q_pop_o = 1'b1;
          endcase
        end
      end
      ST_ERR:  state_d = ST_LMUL;
      ST_LMUL: state_d = ST_LACC;
      ST_LACC: begin
        last = idx_q == 4'(LOSS_N - 1);
        cmd_left[CMD_LOSS] = 1'b0;
        state_d = ST_ERR;
      end
      ST_HMUL: state_d = ST_HWR;
      ST_HWR: begin
        last = idx_q == 4'(HID_N - 1);
        cmd_left[CMD_D1] = 1'b0;
        state_d = ST_HMUL;
      end
      ST_UPD2: begin
        last = idx_q == 4'(UPD2_N - 1);
        cmd_left[CMD_UPD2] = 1'b0;
      end
      ST_UPD1: begin
        last = idx_q == 4'(UPD1_N - 1);
        cmd_left[CMD_UPD1] = 1'b0;
      end
      ST_CLR: begin
        last = 1'b1;
        cmd_left[CMD_CLR] = 1'b0;
      end
      default: state_d = ST_IDLE;
    endcase
    if (state_q == ST_LACC || state_q == ST_HWR || state_q == ST_UPD2 ||
        state_q == ST_UPD1 || state_q == ST_CLR) begin
      if (last) begin
        cmd_d   = cmd_left;
        idx_d   = 4'd0;
        state_d = first_phase(cmd_left);
      end else begin
        idx_d = idx_q + 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cmd_q   <= 5'd0;
      idx_q   <= 4'd0;
      out_v_q <= 1'b0;
      lr_q    <= 4'd4;
      leak_q  <= 3'd3;
      errc_q  <= 31'd32768;
      dltc_q  <= 31'd32768;
      loss_q  <= 32'd0;
      for (int i = 0; i < 4; i++) begin
        act_q[i]  <= 32'd0;
        pre_q[i]  <= 32'd0;
        tgt_q[i]  <= 32'd0;
        dhid_q[i] <= 32'd0;
      end
      for (int i = 0; i < 16; i++) begin
        grad_q[i] <= 32'd0;
        w1_q[i]   <= 32'd0;
      end
      for (int i = 0; i < 8; i++) w2_q[i] <= 32'd0;
      for (int i = 0; i < 2; i++) dout_q[i] <= 32'd0;
    end else begin
      state_q <= state_d;
      cmd_q   <= cmd_d;
      idx_q   <= idx_d;
      out_v_q <= out_v_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_LR:    lr_q   <= cfg_data_i[3:0];
          CFG_LEAK:  leak_q <= cfg_data_i[2:0];
          CFG_ERR:   errc_q <= cfg_data_i;
          CFG_DELTA: dltc_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (q_pop_o && q_op_i.kind == OP_WRITE) begin
        if (a < ADDR_PRE) act_q[a[1:0]] <= q_op_i.data;
        else if (a < ADDR_TGT) pre_q[a[1:0]] <= q_op_i.data;
        else if (a < ADDR_GRAD) tgt_q[a[1:0]] <= q_op_i.data;
        else if (a < ADDR_CMD) grad_q[off_grad(a)] <= q_op_i.data;
        else if (a >= ADDR_W1 && a < ADDR_W2) w1_q[a[3:0]] <= q_op_i.data;
        else if (a >= ADDR_W2 && a < ADDR_W2 + 7'd8) w2_q[a[2:0]] <= q_op_i.data;
      end
      case (state_q)
        ST_LACC: begin
          loss_q <= loss_q + sq_rnd[31:0];
          dout_q[idx_q[0]] <= clamp_lim(round_q(lk_q), dltc_q);
        end
        ST_HWR:  dhid_q[idx_q[1:0]] <= clamp_lim(round_q(lk_q), dltc_q);
        ST_UPD2: w2_q[idx_q[2:0]] <= sgd(w2_q[idx_q[2:0]], grad_q[idx_q], lr_q);
        ST_UPD1: w1_q[idx_q] <= sgd(w1_q[idx_q], grad_q[idx_q], lr_q);
        ST_CLR:  loss_q <= 32'd0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o && q_op_i.kind == OP_READ) out_q <= rdata;
    case (state_q)
      ST_ERR:  e_q <= signed'(clamp_lim(64'(diff), errc_q));
      ST_LMUL: begin
        sq_q <= 64'(e_q * e_q);
        lk_q <= 64'(e_q * signed'({1'b0, slope}));
      end
      ST_HMUL: lk_q <= 64'(signed'(act_q[idx_q[1:0]]) * signed'({1'b0, slope}));
      default: ;
    endcase
  end

endmodule

// ===== design/q88_sgd_train_unit.sv =====
// ----------------------------------------------------------------------------
// q88_sgd_train_unit
// Register-mapped Q8.8 training unit with error, delta, SGD update and loss clear commands.
// ----------------------------------------------------------------------------
// A read or a plain write beat is carried out once it reaches the back end
// through the two-entry queue; such beats stream at one per cycle while no
// command runs and, for reads, the output register is free or being taken.
// A write to the command word runs the command sequencer, which holds the queue
// until the error, delta, weight update and loss clear phases of every set bit
// are done. Reads return one beat each; writes none.
module q88_sgd_train_unit import q88_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [30:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // write_data[39:8], word_addr[7:1], write_flag[0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata    // read_data
);

  q_ctrl_t qc;
  op_t     f_op, b_op;
  logic    q_full, q_valid, q_pop;

  q88_front u_front (
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .q_full_i     (q_full),
    .q_ctrl_o     (qc),
    .op_o         (f_op)
  );

  q88_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (qc),
    .op_i   (f_op),
    .full_o (q_full),
    .valid_o(q_valid),
    .op_o   (b_op),
    .pop_i  (q_pop)
  );

  q88_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .q_valid_i    (q_valid),
    .q_op_i       (b_op),
    .q_pop_o      (q_pop),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

endmodule

// ===== design/q88_checker.sv =====
// ----------------------------------------------------------------------------
// q88_checker
// Port-level checks of the training unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module q88_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata
);

  `ASSERT_ON(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
  `ASSERT_ON(a_out_stable, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
  `ASSERT_ALWAYS(a_no_beat_after_reset, clk_i, !rst_ni || $past(rst_ni) || !m_axis_tvalid)

endmodule

bind q88_sgd_train_unit q88_checker u_q88_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);

// ===== dv/tb_q88_sgd_train_unit.sv =====
// ----------------------------------------------------------------------------
// tb_q88_sgd_train_unit
// Stream testbench for the Q8.8 SGD training unit. Bus beats are queued by a
// stimulus process, driven with random gaps, and every read beat is checked
// against a behavioral prediction of the register banks and the commands.
// ----------------------------------------------------------------------------
module tb_q88_sgd_train_unit;
  import q88_pkg::*;

  localparam int W_LOSS = 0, W_D1 = 1, W_UPD2 = 2, W_UPD1 = 3, W_CLR = 4;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [30:0] cfg_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;

  q88_sgd_train_unit uut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Predicted machine state.
  logic signed [31:0] p_act[4], p_pre[4], p_tgt[4], p_grad[16];
  logic signed [31:0] p_w1[16], p_w2[8], p_dout[2], p_dhid[4];
  logic [31:0] p_loss;
  logic [3:0]  p_lr;
  logic [2:0]  p_leak;
  logic [30:0] p_err, p_dlt;

  logic [39:0] beat_q[$];
  logic [31:0] read_q[$];
  int mismatches = 0;
  int hold_off = 0;

  function automatic longint asr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint qmul(longint a, longint b);
    return asr(a * b + (64'sd1 <<< (FRAC_BITS - 1)), FRAC_BITS);
  endfunction

  function automatic longint lim(longint v, logic [30:0] c);
    longint l;
    l = (c == 0) ? 1 : longint'(c);
    if (v < -l) return -l;
    if (v > l - 1) return l - 1;
    return v;
  endfunction

  function automatic longint leak_mul(longint x, logic signed [31:0] z);
    longint s;
    s = (z >= 0) ? (64'sd1 <<< FRAC_BITS) : ((64'sd1 <<< FRAC_BITS) >>> p_leak);
    return qmul(x, s);
  endfunction

  function automatic logic signed [31:0] step_weight(logic signed [31:0] w,
                                                      logic signed [31:0] g);
    longint v;
    v = longint'(w) - asr(longint'(g), p_lr);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return 32'(v);
  endfunction

  task automatic run_train_cmd(logic [31:0] c);
    longint e;
    longint p;
    if (c[W_LOSS]) begin
      for (int i = 0; i < LOSS_N; i++) begin
        e = lim(longint'(p_act[i]) - longint'(p_tgt[i]), p_err);
        p = qmul(e, e);
        p_loss += p[31:0];
        p = lim(leak_mul(e, p_pre[i]), p_dlt);
        p_dout[i] = p[31:0];
      end
    end
    if (c[W_D1])
      for (int i = 0; i < HID_N; i++) begin
        p = lim(leak_mul(longint'(p_act[i]), p_pre[i]), p_dlt);
        p_dhid[i] = p[31:0];
      end
    if (c[W_UPD2]) for (int i = 0; i < UPD2_N; i++) p_w2[i] = step_weight(p_w2[i], p_grad[i]);
    if (c[W_UPD1]) for (int i = 0; i < UPD1_N; i++) p_w1[i] = step_weight(p_w1[i], p_grad[i]);
    if (c[W_CLR]) p_loss = '0;
  endtask

  // Updates the prediction for one accepted beat.
  task automatic predict_access(logic [39:0] b);
    logic [6:0] a;
    logic [6:0] o;
    logic signed [31:0] v;
    logic [31:0] r;
    a = b[7:1];
    v = b[39:8];
    r = '0;
    o = a - ADDR_GRAD;
    if (b[0]) begin
      if (a < ADDR_PRE) p_act[a[1:0]] = v;
      else if (a < ADDR_TGT) p_pre[a[1:0]] = v;
      else if (a < ADDR_GRAD) p_tgt[a[1:0]] = v;
      else if (a < ADDR_CMD) p_grad[o[3:0]] = v;
      else if (a == ADDR_CMD) run_train_cmd(v);
      else if (a >= ADDR_W1 && a < ADDR_W2) p_w1[a[3:0]] = v;
      else if (a >= ADDR_W2 && a < ADDR_W2 + 7'd8) p_w2[a[2:0]] = v;
    end else begin
      if (a >= ADDR_W1 && a < ADDR_W2) r = p_w1[a[3:0]];
      else if (a >= ADDR_W2 && a < ADDR_W2 + 7'd8) r = p_w2[a[2:0]];
      else if (a >= ADDR_DOUT && a < ADDR_DOUT + 7'd2) r = p_dout[a[0]];
      else if (a >= ADDR_DHID && a < ADDR_DHID + 7'd4) r = p_dhid[a[1:0]];
      else if (a == ADDR_LOSS) r = p_loss;
      read_q.push_back(r);
    end
  endtask

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      1: return 32'($signed($urandom_range(0, 1023)) - 512);
      2: return 32'($signed($urandom_range(0, 131071)) - 65536);
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [39:0] mk_beat(bit wr, logic [6:0] a, logic [31:0] d);
    return {d, a, wr};
  endfunction

  task automatic add_rand_beat();
    logic [6:0] a;
    int k;
    k = $urandom_range(0, 99);
    if (k < 8) a = 7'($urandom());
    else if (k < 20) a = ADDR_CMD;
    else if (k < 60) a = 7'($urandom_range(0, 55));
    else a = 7'($urandom_range(32, 76));
    if (a == ADDR_CMD) beat_q.push_back(mk_beat(1'b1, a, {27'($urandom()), 5'($urandom())}));
    else beat_q.push_back(mk_beat(1'($urandom_range(0, 1)), a, rand_value()));
  endtask

  task automatic wait_drained();
    while (beat_q.size() != 0 || s_axis_tvalid || read_q.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic set_reg(logic [1:0] idx, logic [30:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_LR:    p_lr = val[3:0];
      CFG_LEAK:  p_leak = val[2:0];
      CFG_ERR:   p_err = val;
      default:   p_dlt = val;
    endcase
  endtask

  task automatic read_all();
    for (int a = ADDR_W1; a <= ADDR_LOSS; a++) beat_q.push_back(mk_beat(1'b0, 7'(a), '0));
  endtask

  // Acceptance sampled on the rising edge.
  logic s_fire = 1'b0;
  always @(posedge clk_i) s_fire <= s_axis_tvalid && s_axis_tready;

  // Driver: hold each beat until accepted, then a random gap before the next.
  int gap = 0;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (s_fire) begin
        predict_access(s_axis_tdata);
      end
      if (s_axis_tvalid && !s_fire) begin
      end else if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        gap <= gap - 1;
      end else if (beat_q.size() != 0) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= beat_q.pop_front();
        gap <= $urandom_range(0, 1) ? 0 : $urandom_range(0, 9);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver with random stalls and an optional long hold-off.
  int stall = 0;
  always @(negedge clk_i) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      m_axis_tready <= 1'b0;
    end else if (stall > 0) begin
      stall <= stall - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      if (m_axis_tvalid && m_axis_tready) stall <= $urandom_range(0, 2) ? 0 : $urandom_range(0, 9);
    end
  end

  // Monitor.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (read_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected read beat: %h", m_axis_tdata);
      end else begin
        if (read_q[0] !== m_axis_tdata) begin
          mismatches++;
          if (mismatches <= 10)
            $display("read_data mismatch: expected %h actual %h", read_q[0], m_axis_tdata);
        end
        void'(read_q.pop_front());
      end
    end
  end

  initial begin
    foreach (p_act[i]) begin p_act[i] = 0; p_pre[i] = 0; p_tgt[i] = 0; p_dhid[i] = 0; end
    foreach (p_grad[i]) begin p_grad[i] = 0; p_w1[i] = 0; end
    foreach (p_w2[i]) p_w2[i] = 0;
    p_dout[0] = 0; p_dout[1] = 0; p_loss = 0;
    p_lr = 4'd4; p_leak = 3'd3; p_err = 31'd32768; p_dlt = 31'd32768;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    // Directed part.
    beat_q.push_back(mk_beat(1'b1, ADDR_ACT, 32'h7FFF_FFFF));
    beat_q.push_back(mk_beat(1'b1, ADDR_ACT + 7'd1, 32'h8000_0000));
    beat_q.push_back(mk_beat(1'b1, ADDR_TGT, 32'h8000_0000));
    beat_q.push_back(mk_beat(1'b1, ADDR_TGT + 7'd1, 32'h7FFF_FFFF));
    beat_q.push_back(mk_beat(1'b1, ADDR_PRE + 7'd1, 32'hFFFF_FFFF));
    beat_q.push_back(mk_beat(1'b1, ADDR_GRAD, 32'h8000_0000));
    beat_q.push_back(mk_beat(1'b1, ADDR_GRAD + 7'd1, 32'h7FFF_FFFF));
    beat_q.push_back(mk_beat(1'b1, ADDR_W2 + 7'd2, 32'h1234_5678));
    beat_q.push_back(mk_beat(1'b1, ADDR_DOUT, 32'h5555_5555));
    beat_q.push_back(mk_beat(1'b1, 7'd127, 32'hFFFF_FFFF));
    beat_q.push_back(mk_beat(1'b1, ADDR_CMD, 32'h0000_000F));
    beat_q.push_back(mk_beat(1'b1, ADDR_CMD, 32'h0000_0001));
    beat_q.push_back(mk_beat(1'b0, ADDR_LOSS, '0));
    beat_q.push_back(mk_beat(1'b0, ADDR_ACT, '0));
    beat_q.push_back(mk_beat(1'b0, 7'd127, '0));
    beat_q.push_back(mk_beat(1'b1, ADDR_CMD, 32'hFFFF_FFF0));
    read_all();
    wait_drained();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin set_reg(CFG_LR, 31'd0); set_reg(CFG_LEAK, 31'd0);
                 set_reg(CFG_ERR, 31'd1); set_reg(CFG_DELTA, 31'd1); end
        1: begin set_reg(CFG_LR, 31'd15); set_reg(CFG_LEAK, 31'd7);
                 set_reg(CFG_ERR, 31'h4000_0000); set_reg(CFG_DELTA, 31'h4000_0000); end
        2: begin set_reg(CFG_ERR, 31'd0); set_reg(CFG_DELTA, 31'h7FFF_FFFF); end
        default: begin
          set_reg(CFG_LR, 31'($urandom_range(0, 15)));
          set_reg(CFG_LEAK, 31'($urandom_range(0, 7)));
          set_reg(CFG_ERR, 31'($urandom_range(1, 70000)));
          set_reg(CFG_DELTA, 31'($urandom_range(1, 70000)));
        end
      endcase
      if (ph == 3) hold_off = 300;
      for (int n = 0; n < 170; n++) add_rand_beat();
      read_all();
      wait_drained();
    end

    if (mismatches == 0 && read_q.size() == 0) begin
      $display("tb_q88_sgd_train_unit: clean");
    end else begin
      $display("tb_q88_sgd_train_unit: errors");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("tb_q88_sgd_train_unit: errors");
    $finish;
  end
endmodule

// ===== q88_sgd_train_unit.f =====
+incdir+design
design/q88_pkg.sv
design/q88_front.sv
design/q88_queue.sv
design/q88_back.sv
design/q88_sgd_train_unit.sv
design/q88_checker.sv
dv/tb_q88_sgd_train_unit.sv
